FILE: hdl/rgbed_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbed_pkg
// shared constants, types and helpers of the rgb error diffusion ditherer
// ----------------------------------------------------------------------------
package rgbed_pkg;

	// default frame limits
	localparam int MAX_WIDTH_DEF  = 1024;
	localparam int MAX_HEIGHT_DEF = 1024;

	// configuration port
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int CFG_SIZE_W = 11;

	localparam logic [1:0] REG_WIDTH    = 2'd0;
	localparam logic [1:0] REG_HEIGHT   = 2'd1;
	localparam logic [1:0] REG_POLARITY = 2'd2;

	localparam logic [CFG_SIZE_W-1:0] WIDTH_RST  = 11'd1024;
	localparam logic [CFG_SIZE_W-1:0] HEIGHT_RST = 11'd1024;
	localparam logic                  POL_RST    = 1'b1;

	// payload widths
	localparam int PIX_W     = 8;
	localparam int POS_OUT_W = 10;
	localparam int SUM_W     = 15;
	localparam int OUT_W     = 1 + 2 * POS_OUT_W + 2;

	// luma weights and the reciprocal of 100 (exact for sums up to 25500)
	localparam logic [SUM_W-1:0] W_RED   = 15'd30;
	localparam logic [SUM_W-1:0] W_GREEN = 15'd59;
	localparam logic [SUM_W-1:0] W_BLUE  = 15'd11;
	localparam int RECIP_W    = 13;
	localparam logic [RECIP_W-1:0] GRAY_RECIP = 13'd5243;
	localparam int GRAY_SHIFT = 19;

	// quantizer and error shares
	localparam logic [PIX_W-1:0] THRESH  = 8'd127;
	localparam logic [PIX_W-1:0] PIX_MAX = 8'd255;
	localparam int VAL_W   = 10;
	localparam int ERR_W   = 9;
	localparam int PROD_W  = 12;
	localparam int RC_W    = 7;
	localparam int DIAG_W  = 4;
	localparam int BELOW_W = 8;
	localparam int SHARE_SHIFT = 4;
	localparam logic signed [PROD_W-1:0] SH7 = 12'sd7;
	localparam logic signed [PROD_W-1:0] SH5 = 12'sd5;
	localparam logic signed [PROD_W-1:0] SH3 = 12'sd3;
	localparam logic signed [PROD_W-1:0] DIV_BIAS = 12'sd15;

	// queue depths
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 2;

	typedef struct packed {
		logic row_zero;
		logic last_col;
		logic last_row;
	} pos_flags_t;

	// divide by 16, truncating toward zero
	function automatic logic signed [PROD_W-1:0] div16_trunc(input logic signed [PROD_W-1:0] x);
		if (x < 0) begin
			return (x + DIV_BIAS) >>> SHARE_SHIFT;
		end
		return x >>> SHARE_SHIFT;
	endfunction

endpackage

FILE: hdl/rgbed_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbed_fifo
// small register queue with show-ahead read and fill level
// ----------------------------------------------------------------------------
module rgbed_fifo #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         wr_en,
	input  logic [DATA_W-1:0]            wr_data,
	input  logic                         rd_en,
	output logic [DATA_W-1:0]            rd_data,
	output logic                         full,
	output logic                         empty,
	output logic [$clog2(DEPTH+1)-1:0]   level
);
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);

	logic [DATA_W-1:0] store_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [LVL_W-1:0]  level_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (level_q == LVL_W'(DEPTH));
	assign empty   = (level_q == '0);
	assign level   = level_q;
	assign rd_data = store_q[rd_ptr_q];
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				level_q <= level_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: hdl/rgbed_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbed_front
// pixel intake: raster position, row and frame flags, gray conversion
// ----------------------------------------------------------------------------
module rgbed_front #(
	parameter int MAX_WIDTH  = rgbed_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rgbed_pkg::MAX_HEIGHT_DEF,
	parameter int MID_W      = 32
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic [rgbed_pkg::CFG_SIZE_W-1:0]             cfg_width,
	input  logic [rgbed_pkg::CFG_SIZE_W-1:0]             cfg_height,
	input  logic                                         push,
	output logic                                         full,
	input  logic [rgbed_pkg::PIX_W-1:0]                  red,
	input  logic [rgbed_pkg::PIX_W-1:0]                  green,
	input  logic [rgbed_pkg::PIX_W-1:0]                  blue,
	input  logic [$clog2(rgbed_pkg::MID_DEPTH+1)-1:0]    mid_level,
	output logic                                         mid_push,
	output logic [MID_W-1:0]                             mid_data
);
	import rgbed_pkg::*;

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = $clog2(MAX_HEIGHT);
	localparam int WW    = (CW + 1 > CFG_SIZE_W) ? CW + 1 : CFG_SIZE_W;
	localparam int HW    = (RW + 1 > CFG_SIZE_W) ? RW + 1 : CFG_SIZE_W;
	localparam int LVL_W = $clog2(MID_DEPTH + 1);
	localparam int PRD_W = SUM_W + RECIP_W;

	logic [CW-1:0]        col_q;
	logic [RW-1:0]        row_q;
	logic [WW-1:0]        w_eff;
	logic [HW-1:0]        h_eff;
	logic                 last_col;
	logic                 last_row;
	logic                 accept;

	logic                 valid_s1;
	logic [SUM_W-1:0]     sum_s1;
	logic [CW-1:0]        col_s1;
	logic [POS_OUT_W-1:0] row_s1;
	pos_flags_t           flags_s1;

	logic [PRD_W-1:0]     prod;
	logic [PIX_W-1:0]     gray;

	// effective frame size
	always_comb begin
		if (cfg_width == '0) begin
			w_eff = WW'(1);
		end else if (WW'(cfg_width) > WW'(MAX_WIDTH)) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(cfg_width);
		end
		if (cfg_height == '0) begin
			h_eff = HW'(1);
		end else if (HW'(cfg_height) > HW'(MAX_HEIGHT)) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(cfg_height);
		end
	end

	assign last_col = (WW'(col_q) + 1'b1) >= w_eff;
	assign last_row = (HW'(row_q) + 1'b1) >= h_eff;

	// room is counted against words still in the conversion stage
	assign full   = (({1'b0, mid_level} + (LVL_W + 1)'(valid_s1)) >= (LVL_W + 1)'(MID_DEPTH));
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sum_s1   <= SUM_W'(red) * W_RED + SUM_W'(green) * W_GREEN + SUM_W'(blue) * W_BLUE;
			col_s1   <= col_q;
			row_s1   <= POS_OUT_W'(row_q);
			flags_s1 <= '{row_zero: (row_q == '0), last_col: last_col, last_row: last_row};
		end
	end

	// divide by 100 through the reciprocal
	assign prod     = PRD_W'(sum_s1) * PRD_W'(GRAY_RECIP);
	assign gray     = prod[GRAY_SHIFT +: PIX_W];
	assign mid_push = valid_s1;
	assign mid_data = {gray, col_s1, row_s1, flags_s1};

endmodule

FILE: hdl/rgbed_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgbed_back
// error diffusion: line error memory, carries, quantizer and result word
// ----------------------------------------------------------------------------
module rgbed_back #(
	parameter int MAX_WIDTH = rgbed_pkg::MAX_WIDTH_DEF,
	parameter int MID_W     = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_polarity,
	input  logic                        mid_empty,
	input  logic [MID_W-1:0]            mid_data,
	output logic                        mid_pop,
	input  logic                        out_full,
	output logic                        out_push,
	output logic [rgbed_pkg::OUT_W-1:0] out_data
);
	import rgbed_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);

	logic signed [BELOW_W-1:0] below_mem [MAX_WIDTH];

	logic [PIX_W-1:0]          in_gray;
	logic [CW-1:0]             in_col;
	logic [POS_OUT_W-1:0]      in_row;
	pos_flags_t                in_flags;

	logic                      valid_s1;
	logic [PIX_W-1:0]          gray_s1;
	logic [CW-1:0]             col_s1;
	logic [POS_OUT_W-1:0]      row_s1;
	pos_flags_t                flags_s1;
	logic signed [BELOW_W-1:0] rd_s1;

	logic signed [RC_W-1:0]    rc_q;
	logic signed [DIAG_W-1:0]  diag_q;
	logic signed [BELOW_W-1:0] pend_q;
	logic [CW-1:0]             prev_col_q;

	logic                      fire;
	logic                      load;
	logic                      col_nz;
	logic                      spread;
	logic signed [VAL_W-1:0]   v_sum;
	logic [PIX_W-1:0]          v_clamp;
	logic                      dark;
	logic signed [ERR_W-1:0]   err;
	logic signed [PROD_W-1:0]  err_x;
	logic signed [RC_W-1:0]    s7;
	logic signed [BELOW_W-1:0] s5;
	logic signed [BELOW_W-1:0] s3;
	logic signed [DIAG_W-1:0]  s1;
	logic signed [BELOW_W-1:0] wr_data;
	logic signed [BELOW_W-1:0] pend_next;
	logic                      pix_bit;

	assign {in_gray, in_col, in_row, in_flags} = mid_data;

	assign fire    = valid_s1 && !out_full;
	assign load    = !mid_empty && (!valid_s1 || fire);
	assign mid_pop = load;

	// quantizer and share split
	always_comb begin
		col_nz  = (col_s1 != '0);
		spread  = col_nz && !flags_s1.last_col && !flags_s1.last_row;
		v_sum   = $signed(VAL_W'(gray_s1))
		        + (col_nz ? VAL_W'(rc_q) : '0)
		        + (flags_s1.row_zero ? '0 : VAL_W'(rd_s1));
		if (v_sum < 0) begin
			v_clamp = '0;
		end else if (v_sum > $signed(VAL_W'(PIX_MAX))) begin
			v_clamp = PIX_MAX;
		end else begin
			v_clamp = v_sum[PIX_W-1:0];
		end
		dark  = (v_clamp <= THRESH);
		err   = dark ? $signed(ERR_W'(v_clamp))
		             : $signed(ERR_W'(v_clamp)) - $signed(ERR_W'(PIX_MAX));
		err_x = PROD_W'(err);
		s7    = spread ? RC_W'(div16_trunc(err_x * SH7)) : '0;
		s5    = spread ? BELOW_W'(div16_trunc(err_x * SH5)) : '0;
		s3    = spread ? BELOW_W'(div16_trunc(err_x * SH3)) : '0;
		s1    = spread ? DIAG_W'(div16_trunc(err_x)) : '0;
		// left neighbor's entry is finished now that its 3/16 share is known
		wr_data   = pend_q + s3;
		pend_next = (col_nz ? BELOW_W'(diag_q) : '0) + s5;
		pix_bit   = dark ^ !cfg_polarity;
	end

	assign out_push = fire;
	assign out_data = {pix_bit, POS_OUT_W'(col_s1), row_s1, flags_s1.last_col,
	                   flags_s1.last_col && flags_s1.last_row};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			rc_q       <= '0;
			diag_q     <= '0;
			pend_q     <= '0;
			prev_col_q <= '0;
		end else begin
			if (load) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (fire) begin
				rc_q       <= flags_s1.last_col ? '0 : s7;
				diag_q     <= flags_s1.last_col ? '0 : s1;
				pend_q     <= pend_next;
				prev_col_q <= col_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			gray_s1  <= in_gray;
			col_s1   <= in_col;
			row_s1   <= in_row;
			flags_s1 <= in_flags;
		end
	end

	// line error memory; entries still pending in the carries are forwarded
	// to a read of the same column (one-pixel rows read their own column)
	always_ff @(posedge clk) begin
		if (fire) begin
			below_mem[prev_col_q] <= wr_data;
		end
		if (load) begin
			if (fire && (col_s1 == in_col)) begin
				rd_s1 <= pend_next;
			end else if (prev_col_q == in_col) begin
				rd_s1 <= fire ? wr_data : pend_q;
			end else begin
				rd_s1 <= below_mem[in_col];
			end
		end
	end

endmodule

FILE: hdl/rgb_error_diffusion_dither_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_error_diffusion_dither_top
// rgb to one-bit ink dithering with floyd-steinberg error diffusion
// ----------------------------------------------------------------------------
// usage
//   pixel words enter in raster order: present red/green/blue with push,
//   a word is taken on a clock edge with push high and full low
//   result words leave through a queue: while empty is low the oldest word
//   is on pixel_bit/column/row/end_of_row/end_of_frame, pop takes it
//   frame size and ink polarity are written over the apb port while idle
// timing
//   one pixel per clock sustained while pop keeps up; a result shows after its
//   pixel passes gray stage, middle queue, error memory read, diffusion step
//   the rate is set by the right-neighbor carry loop, which closes in the
//   single diffusion step
// reset
//   position counters and carries clear, both queues empty, size registers
//   go to 1024 x 1024 and polarity to 1; the line error memory is not
//   cleared, the first row of a frame never uses it
// stalls
//   if pop is held low the result queue fills, the diffusion step holds,
//   the middle queue fills and full rises; nothing is dropped
// ----------------------------------------------------------------------------
module rgb_error_diffusion_dither_top #(
	parameter int MAX_WIDTH  = rgbed_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = rgbed_pkg::MAX_HEIGHT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// pixel input queue
	input  logic                             push,
	output logic                             full,
	input  logic [rgbed_pkg::PIX_W-1:0]      red,
	input  logic [rgbed_pkg::PIX_W-1:0]      green,
	input  logic [rgbed_pkg::PIX_W-1:0]      blue,
	// result queue
	output logic                             empty,
	input  logic                             pop,
	output logic                             pixel_bit,
	output logic [rgbed_pkg::POS_OUT_W-1:0]  column,
	output logic [rgbed_pkg::POS_OUT_W-1:0]  row,
	output logic                             end_of_row,
	output logic                             end_of_frame,
	// configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [rgbed_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [rgbed_pkg::APB_DATA_W-1:0] pwdata,
	output logic [rgbed_pkg::APB_DATA_W-1:0] prdata,
	output logic                             pready
);
	import rgbed_pkg::*;

	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int MID_W     = PIX_W + CW + POS_OUT_W + $bits(pos_flags_t);
	localparam int MID_LVL_W = $clog2(MID_DEPTH + 1);
	localparam int OUT_LVL_W = $clog2(OUT_DEPTH + 1);

	// configuration registers
	logic [CFG_SIZE_W-1:0] cfg_width_q;
	logic [CFG_SIZE_W-1:0] cfg_height_q;
	logic                  cfg_polarity_q;
	logic                  cfg_wr;

	// front to back queue
	logic                  mid_push;
	logic [MID_W-1:0]      mid_wdata;
	logic [MID_W-1:0]      mid_rdata;
	logic                  mid_pop;
	logic                  mid_full;
	logic                  mid_empty;
	logic [MID_LVL_W-1:0]  mid_level;

	// back to result queue
	logic                  out_push;
	logic [OUT_W-1:0]      out_wdata;
	logic [OUT_W-1:0]      out_rdata;
	logic                  out_full;
	logic [OUT_LVL_W-1:0]  out_level;

	// apb access, always ready
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_width_q    <= WIDTH_RST;
			cfg_height_q   <= HEIGHT_RST;
			cfg_polarity_q <= POL_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_WIDTH: begin
					cfg_width_q <= pwdata[CFG_SIZE_W-1:0];
				end
				REG_HEIGHT: begin
					cfg_height_q <= pwdata[CFG_SIZE_W-1:0];
				end
				REG_POLARITY: begin
					cfg_polarity_q <= pwdata[0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_WIDTH:    prdata = APB_DATA_W'(cfg_width_q);
			REG_HEIGHT:   prdata = APB_DATA_W'(cfg_height_q);
			REG_POLARITY: prdata = APB_DATA_W'(cfg_polarity_q);
			default:      prdata = '0;
		endcase
	end

	// intake: position tracking and gray conversion
	rgbed_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MID_W      (MID_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_width  (cfg_width_q),
		.cfg_height (cfg_height_q),
		.push       (push),
		.full       (full),
		.red        (red),
		.green      (green),
		.blue       (blue),
		.mid_level  (mid_level),
		.mid_push   (mid_push),
		.mid_data   (mid_wdata)
	);

	// decouples intake from the diffusion step
	rgbed_fifo #(
		.DATA_W  (MID_W),
		.DEPTH   (MID_DEPTH)
	) u_mid_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wdata),
		.rd_en   (mid_pop),
		.rd_data (mid_rdata),
		.full    (mid_full),
		.empty   (mid_empty),
		.level   (mid_level)
	);

	// error diffusion and quantizer
	rgbed_back #(
		.MAX_WIDTH    (MAX_WIDTH),
		.MID_W        (MID_W)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_polarity (cfg_polarity_q),
		.mid_empty    (mid_empty),
		.mid_data     (mid_rdata),
		.mid_pop      (mid_pop),
		.out_full     (out_full),
		.out_push     (out_push),
		.out_data     (out_wdata)
	);

	// result queue, lets the diffusion step run while a word waits
	rgbed_fifo #(
		.DATA_W  (OUT_W),
		.DEPTH   (OUT_DEPTH)
	) u_out_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (out_push),
		.wr_data (out_wdata),
		.rd_en   (pop),
		.rd_data (out_rdata),
		.full    (out_full),
		.empty   (empty),
		.level   (out_level)
	);

	assign {pixel_bit, column, row, end_of_row, end_of_frame} = out_rdata;

	// credit in the front already keeps the middle queue from overflowing;
	// the level of the result queue is not needed outside
	logic unused_levels;
	assign unused_levels = mid_full ^ (^out_level);

endmodule
